FILE: sv/bs27_pkg.sv
// bs27_pkg: shared constants, types and structs of the 27-point block stencil.
// Used by every module of the block; depends on nothing.
package bs27_pkg;

  // Geometry limits
  localparam int MAX_ROW_NODES  = 64;
  localparam int MAX_PLANE_ROWS = 64;
  localparam int CZ_W           = 16;

  // Sample window: two planes, two rows and three nodes of history
  localparam int SW_DEPTH = 2 * MAX_ROW_NODES * MAX_PLANE_ROWS + 2 * MAX_ROW_NODES + 3;
  localparam int SW_AW    = $clog2(SW_DEPTH);
  localparam int SA_W     = SW_AW + 2;

  // Coefficient table: one row of nine block elements per (class, neighbor)
  localparam int NB_COUNT  = 27;
  localparam int SLOTS     = 9;
  localparam int COEF_ROWS = NB_COUNT * NB_COUNT;
  localparam int CR_AW     = $clog2(COEF_ROWS);

  // Counter and size widths
  localparam int RN_W  = $clog2(MAX_ROW_NODES + 1);
  localparam int YR_W  = $clog2(MAX_PLANE_ROWS + 1);
  localparam int XI_W  = $clog2(MAX_ROW_NODES);
  localparam int YI_W  = $clog2(MAX_PLANE_ROWS);
  localparam int ZN_W  = CZ_W + 1;
  localparam int P_W   = RN_W + YR_W;
  localparam int POS_W = $clog2(MAX_ROW_NODES * MAX_PLANE_ROWS * (2 ** CZ_W) + 1);

  // Arithmetic
  localparam int DATA_W = 32;
  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = PROD_W + 7;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_SAMPLE = 2'd1,
    ACT_DRAIN  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  localparam logic [1:0] REG_CELLS_X = 2'd0;
  localparam logic [1:0] REG_CELLS_Y = 2'd1;
  localparam logic [1:0] REG_CELLS_Z = 2'd2;

  // Coefficient write request
  typedef struct packed {
    logic             en;
    logic [3:0]       slot;
    logic [CR_AW-1:0] row;
    word_t            data;
  } coef_wr_t;

  // MAC pipeline control
  typedef struct packed {
    logic clr;
    logic vld;
    logic use_nb;
  } mac_ctl_t;

  // Finished result vector
  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
    logic  clip;
  } mac_res_t;

endpackage

FILE: sv/bs27_in_if.sv
// bs27_in_if: input item channel of the block stencil.
// Depends on nothing but the signal widths of the work fields.
interface bs27_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [4:0]         coef_class;
  logic [4:0]         coef_neighbor;
  logic [3:0]         coef_slot;
  logic signed [31:0] coef_value;
  logic signed [31:0] sample_x;
  logic signed [31:0] sample_y;
  logic signed [31:0] sample_z;

  modport source (output valid, action, coef_class, coef_neighbor, coef_slot,
                  coef_value, sample_x, sample_y, sample_z, input ready);
  modport sink   (input valid, action, coef_class, coef_neighbor, coef_slot,
                  coef_value, sample_x, sample_y, sample_z, output ready);
endinterface

FILE: sv/bs27_out_if.sv
// bs27_out_if: result item channel of the block stencil.
// Depends on nothing.
interface bs27_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_x;
  logic signed [31:0] result_y;
  logic signed [31:0] result_z;
  logic               node_last;
  logic               clipped;

  modport source (output valid, result_x, result_y, result_z, node_last, clipped,
                  input ready);
  modport sink   (input valid, result_x, result_y, result_z, node_last, clipped,
                  output ready);
endinterface

FILE: sv/bs27_cfg_if.sv
// bs27_cfg_if: configuration write channel of the block stencil.
// Depends on nothing.
interface bs27_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/bs27_coef_store.sv
// bs27_coef_store: coefficient table, nine banks of one block element each.
// Clears itself after reset, one row a cycle. Depends on bs27_pkg.
module bs27_coef_store (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bs27_pkg::coef_wr_t                wr,
  input  logic [bs27_pkg::CR_AW-1:0]        rd_row,
  output bs27_pkg::word_t                   rd_data [bs27_pkg::SLOTS],
  output logic                              busy
);

  logic [bs27_pkg::CR_AW-1:0] clr_row_r;
  logic                       busy_r;

  // Clearing sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_row_r <= '0;
      busy_r    <= 1'b1;
    end else if (busy_r) begin
      if (clr_row_r == bs27_pkg::CR_AW'(bs27_pkg::COEF_ROWS - 1)) begin
        busy_r <= 1'b0;
      end
      clr_row_r <= clr_row_r + bs27_pkg::CR_AW'(1);
    end
  end

  assign busy = busy_r;

  // One bank per block element; a load writes one bank, a read gets all nine
  for (genvar g = 0; g < bs27_pkg::SLOTS; g++) begin : g_bank
    bs27_pkg::word_t mem [bs27_pkg::COEF_ROWS];

    always_ff @(posedge clk) begin
      if (busy_r) begin
        mem[clr_row_r] <= '0;
      end else if (wr.en && wr.slot == 4'(g)) begin
        mem[wr.row] <= wr.data;
      end
      rd_data[g] <= mem[rd_row];
    end
  end

endmodule

FILE: sv/bs27_win_store.sv
// bs27_win_store: circular window of node vectors, one write and one read port.
// Read data is registered. Depends on bs27_pkg.
module bs27_win_store (
  input  logic                        clk,
  input  logic                        we,
  input  logic [bs27_pkg::SW_AW-1:0]  waddr,
  input  logic [3*bs27_pkg::DATA_W-1:0] wdata,
  input  logic [bs27_pkg::SW_AW-1:0]  raddr,
  output logic [3*bs27_pkg::DATA_W-1:0] rdata
);

  logic [3*bs27_pkg::DATA_W-1:0] mem [bs27_pkg::SW_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/bs27_mac.sv
// bs27_mac: nine multipliers, three wide accumulators, rounding and saturation.
// One neighbor block per cycle. Depends on bs27_pkg.
module bs27_mac (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bs27_pkg::mac_ctl_t            ctl,
  input  bs27_pkg::word_t               coef [bs27_pkg::SLOTS],
  input  logic [3*bs27_pkg::DATA_W-1:0] samp,
  output bs27_pkg::mac_res_t            res
);

  localparam int SH_W = bs27_pkg::ACC_W - 16;

  logic signed [bs27_pkg::PROD_W-1:0] prod_r [bs27_pkg::SLOTS];
  logic                               pv_r;
  logic signed [bs27_pkg::ACC_W-1:0]  acc_r [3];
  logic [2:0]                         clip_c;
  bs27_pkg::word_t                    fin_c [3];

  // Stage 1: block element times vector component
  for (genvar g = 0; g < bs27_pkg::SLOTS; g++) begin : g_mul
    bs27_pkg::word_t                    comp;
    logic signed [bs27_pkg::PROD_W-1:0] mul;
    assign comp = bs27_pkg::word_t'(samp[(g%3)*bs27_pkg::DATA_W +: bs27_pkg::DATA_W]);
    // full-width signed product
    assign mul  = coef[g] * comp;
    always_ff @(posedge clk) begin
      if (ctl.vld) begin
        prod_r[g] <= ctl.use_nb ? mul : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= ctl.vld;
    end
  end

  // Stage 2: exact row sums
  for (genvar r = 0; r < 3; r++) begin : g_acc
    always_ff @(posedge clk) begin
      if (ctl.clr) begin
        acc_r[r] <= '0;
      end else if (pv_r) begin
        acc_r[r] <= acc_r[r] + bs27_pkg::ACC_W'(prod_r[3*r])
                             + bs27_pkg::ACC_W'(prod_r[3*r+1])
                             + bs27_pkg::ACC_W'(prod_r[3*r+2]);
      end
    end

    // Round half up to Q15.16, then saturate
    logic signed [bs27_pkg::ACC_W-1:0] rnd;
    logic signed [SH_W-1:0]            sh;
    always_comb begin
      rnd = acc_r[r] + bs27_pkg::ACC_W'(32'sd32768);
      sh  = SH_W'(rnd >>> 16);
      if (sh > SH_W'(64'sh7FFF_FFFF)) begin
        fin_c[r]  = 32'sh7FFF_FFFF;
        clip_c[r] = 1'b1;
      end else if (sh < -SH_W'(64'sh8000_0000)) begin
        fin_c[r]  = 32'sh8000_0000;
        clip_c[r] = 1'b1;
      end else begin
        fin_c[r]  = bs27_pkg::word_t'(sh[bs27_pkg::DATA_W-1:0]);
        clip_c[r] = 1'b0;
      end
    end
  end

  assign res.x    = fin_c[0];
  assign res.y    = fin_c[1];
  assign res.z    = fin_c[2];
  assign res.clip = |clip_c;

endmodule

FILE: sv/block_stencil_27pt_apply_core.sv
// block_stencil_27pt_apply_core: 27-point 3x3 block stencil product on a 3D node grid.
// Depends on bs27_pkg, the three channel interfaces, bs27_coef_store,
// bs27_win_store and bs27_mac.
//
// Usage:
//   cfg_ch writes cells_x (index 0), cells_y (1), cells_z (2); a write restarts
//   the node stream. Write only while the block is idle. After a write the
//   input stays stalled while the mesh sizes settle.
//   in_ch takes one item at a time: coefficient loads, node samples in raster
//   order, and drain ticks. A load or an item that emits nothing leaves in_ch
//   ready for the next item. A sample or drain that completes a node starts
//   a sweep over the 27 neighbor blocks, one block per cycle through nine
//   multipliers, followed by the read, product and accumulator registers;
//   rounding is combinational, and the next item is taken once the result is
//   in the output register. The block keeps taking items that emit nothing
//   while out_ch is stalled, and waits before writing a new result.
//   Reset: cells registers go to 1, positions to 0, and the coefficient table is
//   cleared in a sweep over its 729 rows during which in_ch is not ready.
//   Config writes are taken at any time.
module block_stencil_27pt_apply_core (
  input  logic          clk,
  input  logic          rst_n,
  bs27_in_if.sink       in_ch,
  bs27_out_if.source    out_ch,
  bs27_cfg_if.sink      cfg_ch
);

  localparam int CMP_W = bs27_pkg::POS_W + 1;
  localparam logic signed [bs27_pkg::SA_W-1:0] SW_S = bs27_pkg::SA_W'(bs27_pkg::SW_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration and derived mesh sizes
  logic [5:0]                   cells_x_r, cells_y_r;
  logic [bs27_pkg::CZ_W-1:0]    cells_z_r;
  logic [bs27_pkg::RN_W-1:0]    rn_c, rn_r;
  logic [bs27_pkg::YR_W-1:0]    yr_c, yr_r;
  logic [bs27_pkg::ZN_W-1:0]    zn_r;
  logic [bs27_pkg::P_W-1:0]     p_r, look_r;
  logic [bs27_pkg::POS_W-1:0]   t_r;
  logic [1:0]                   settle_r;

  // Stream positions
  logic [bs27_pkg::POS_W-1:0]   in_pos_r, out_pos_r, new_pos;
  logic [bs27_pkg::SW_AW-1:0]   in_addr_r, oa_r;
  logic [bs27_pkg::XI_W-1:0]    oi_r;
  logic [bs27_pkg::YI_W-1:0]    oj_r;
  logic [bs27_pkg::CZ_W-1:0]    ok_r;

  // Neighbor sweep
  logic [1:0]                   dx_r, dy_r, dz_r;
  logic [4:0]                   nb_r;
  logic                         fl_r, v1_r, u1_r;

  // Output register
  logic                         out_vld_r;
  bs27_pkg::mac_res_t           out_res_r;
  logic                         out_last_r;

  logic                         cfg_wr, accept, step_samp, step_emit, out_load, is_last;
  logic                         coef_busy, in_mesh, last_nb;
  bs27_pkg::action_t            act;
  bs27_pkg::coef_wr_t           coef_wr;
  logic [bs27_pkg::CR_AW-1:0]   crow;
  bs27_pkg::word_t              coef_rd [bs27_pkg::SLOTS];
  logic [3*bs27_pkg::DATA_W-1:0] win_rd;
  bs27_pkg::mac_ctl_t           mac_ctl;
  bs27_pkg::mac_res_t           mac_res;
  logic [1:0]                   cx, cy, cz;
  logic [4:0]                   cls;
  logic signed [bs27_pkg::SA_W-1:0] rn_s, p_s, offx, offy, offz, nsum, nadj;
  logic                         okx, oky, okz;

  // Handshakes
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr = cfg_ch.valid && (cfg_ch.index == bs27_pkg::REG_CELLS_X ||
                                   cfg_ch.index == bs27_pkg::REG_CELLS_Y ||
                                   cfg_ch.index == bs27_pkg::REG_CELLS_Z);
  assign in_ch.ready = (state_r == ST_IDLE) && (settle_r == 2'd0) && !coef_busy;
  assign accept = in_ch.valid && in_ch.ready;
  assign act    = bs27_pkg::action_t'(in_ch.action);

  // Mesh sizes, zero acting as one, capped at the limits
  always_comb begin
    rn_c = ((cells_x_r == 6'd0) ? bs27_pkg::RN_W'(1) : bs27_pkg::RN_W'(cells_x_r))
           + bs27_pkg::RN_W'(1);
    if (rn_c > bs27_pkg::RN_W'(bs27_pkg::MAX_ROW_NODES)) begin
      rn_c = bs27_pkg::RN_W'(bs27_pkg::MAX_ROW_NODES);
    end
    yr_c = ((cells_y_r == 6'd0) ? bs27_pkg::YR_W'(1) : bs27_pkg::YR_W'(cells_y_r))
           + bs27_pkg::YR_W'(1);
    if (yr_c > bs27_pkg::YR_W'(bs27_pkg::MAX_PLANE_ROWS)) begin
      yr_c = bs27_pkg::YR_W'(bs27_pkg::MAX_PLANE_ROWS);
    end
  end

  always_ff @(posedge clk) begin
    rn_r   <= rn_c;
    yr_r   <= yr_c;
    zn_r   <= ((cells_z_r == '0) ? bs27_pkg::ZN_W'(1) : bs27_pkg::ZN_W'(cells_z_r))
              + bs27_pkg::ZN_W'(1);
    p_r    <= bs27_pkg::P_W'(rn_r * yr_r);
    t_r    <= bs27_pkg::POS_W'(p_r * zn_r);
    look_r <= p_r + bs27_pkg::P_W'(rn_r) + bs27_pkg::P_W'(1);
  end

  // Coefficient load
  assign coef_wr.en   = accept && act == bs27_pkg::ACT_LOAD &&
                        in_ch.coef_class < 5'd27 && in_ch.coef_neighbor < 5'd27 &&
                        in_ch.coef_slot < 4'd9;
  assign coef_wr.slot = in_ch.coef_slot;
  assign coef_wr.row  = bs27_pkg::CR_AW'(in_ch.coef_class) * bs27_pkg::CR_AW'(bs27_pkg::NB_COUNT)
                        + bs27_pkg::CR_AW'(in_ch.coef_neighbor);
  assign coef_wr.data = in_ch.coef_value;

  // Sample write and emission check
  assign step_samp = accept && act == bs27_pkg::ACT_SAMPLE && in_pos_r < t_r;
  assign new_pos   = in_pos_r + bs27_pkg::POS_W'(step_samp);
  assign step_emit = accept && (act == bs27_pkg::ACT_SAMPLE || act == bs27_pkg::ACT_DRAIN) &&
                     out_pos_r < t_r &&
                     ({1'b0, new_pos} > {1'b0, out_pos_r} + CMP_W'(look_r) || new_pos == t_r);

  // Boundary class of the node being emitted
  always_comb begin
    cx = (oi_r == '0) ? 2'd0 :
         (bs27_pkg::RN_W'(oi_r) == rn_r - bs27_pkg::RN_W'(1)) ? 2'd2 : 2'd1;
    cy = (oj_r == '0) ? 2'd0 :
         (bs27_pkg::YR_W'(oj_r) == yr_r - bs27_pkg::YR_W'(1)) ? 2'd2 : 2'd1;
    cz = (ok_r == '0) ? 2'd0 :
         (bs27_pkg::ZN_W'(ok_r) == zn_r - bs27_pkg::ZN_W'(1)) ? 2'd2 : 2'd1;
    cls  = 5'(cx) + 5'(cy) * 5'd3 + 5'(cz) * 5'd9;
    crow = bs27_pkg::CR_AW'(cls) * bs27_pkg::CR_AW'(bs27_pkg::NB_COUNT)
           + bs27_pkg::CR_AW'(nb_r);
  end

  // Neighbor in mesh and its window address
  always_comb begin
    okx = (dx_r == 2'd0) ? (cx != 2'd0) : (dx_r == 2'd2) ? (cx != 2'd2) : 1'b1;
    oky = (dy_r == 2'd0) ? (cy != 2'd0) : (dy_r == 2'd2) ? (cy != 2'd2) : 1'b1;
    okz = (dz_r == 2'd0) ? (cz != 2'd0) : (dz_r == 2'd2) ? (cz != 2'd2) : 1'b1;
    in_mesh = okx && oky && okz;
    rn_s = $signed(bs27_pkg::SA_W'(rn_r));
    p_s  = $signed(bs27_pkg::SA_W'(p_r));
    offx = (dx_r == 2'd0) ? -bs27_pkg::SA_W'(1) : (dx_r == 2'd2) ? bs27_pkg::SA_W'(1) : '0;
    offy = (dy_r == 2'd0) ? -rn_s : (dy_r == 2'd2) ? rn_s : '0;
    offz = (dz_r == 2'd0) ? -p_s : (dz_r == 2'd2) ? p_s : '0;
    nsum = $signed(bs27_pkg::SA_W'(oa_r)) + offx + offy + offz;
    if (nsum < 0) begin
      nadj = nsum + SW_S;
    end else if (nsum >= SW_S) begin
      nadj = nsum - SW_S;
    end else begin
      nadj = nsum;
    end
  end

  assign last_nb  = (nb_r == 5'(bs27_pkg::NB_COUNT - 1));
  assign out_load = (state_r == ST_DONE) && (!out_vld_r || out_ch.ready);
  assign is_last  = (out_pos_r + bs27_pkg::POS_W'(1) == t_r);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (step_emit) state_nxt = ST_RUN;
      ST_RUN:   if (last_nb) state_nxt = ST_FLUSH;
      ST_FLUSH: if (fl_r) state_nxt = ST_DONE;
      ST_DONE:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      v1_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= (state_r == ST_RUN);
    end
    u1_r <= in_mesh;
  end

  // Sweep counters
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      dx_r <= 2'd0;
      dy_r <= 2'd0;
      dz_r <= 2'd0;
      nb_r <= 5'd0;
      fl_r <= 1'b0;
    end else if (state_r == ST_RUN) begin
      nb_r <= nb_r + 5'd1;
      if (dx_r == 2'd2) begin
        dx_r <= 2'd0;
        if (dy_r == 2'd2) begin
          dy_r <= 2'd0;
          dz_r <= dz_r + 2'd1;
        end else begin
          dy_r <= dy_r + 2'd1;
        end
      end else begin
        dx_r <= dx_r + 2'd1;
      end
    end else if (state_r == ST_FLUSH) begin
      fl_r <= 1'b1;
    end
  end

  // Configuration, positions and restart
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_x_r <= 6'd1;
      cells_y_r <= 6'd1;
      cells_z_r <= bs27_pkg::CZ_W'(1);
      settle_r  <= 2'd3;
      in_pos_r  <= '0;
      in_addr_r <= '0;
      out_pos_r <= '0;
      oa_r      <= '0;
      oi_r      <= '0;
      oj_r      <= '0;
      ok_r      <= '0;
    end else if (cfg_wr) begin
      priority case (cfg_ch.index)
        bs27_pkg::REG_CELLS_X: cells_x_r <= cfg_ch.data[5:0];
        bs27_pkg::REG_CELLS_Y: cells_y_r <= cfg_ch.data[5:0];
        default:               cells_z_r <= cfg_ch.data;
      endcase
      settle_r  <= 2'd3;
      in_pos_r  <= '0;
      in_addr_r <= '0;
      out_pos_r <= '0;
      oa_r      <= '0;
      oi_r      <= '0;
      oj_r      <= '0;
      ok_r      <= '0;
    end else begin
      if (settle_r != 2'd0) begin
        settle_r <= settle_r - 2'd1;
      end
      if (step_samp) begin
        in_pos_r  <= new_pos;
        in_addr_r <= (in_addr_r == bs27_pkg::SW_AW'(bs27_pkg::SW_DEPTH - 1)) ? '0
                     : in_addr_r + bs27_pkg::SW_AW'(1);
      end
      if (out_load) begin
        if (is_last) begin
          in_pos_r  <= '0;
          in_addr_r <= '0;
          out_pos_r <= '0;
          oa_r      <= '0;
          oi_r      <= '0;
          oj_r      <= '0;
          ok_r      <= '0;
        end else begin
          out_pos_r <= out_pos_r + bs27_pkg::POS_W'(1);
          oa_r <= (oa_r == bs27_pkg::SW_AW'(bs27_pkg::SW_DEPTH - 1)) ? '0
                  : oa_r + bs27_pkg::SW_AW'(1);
          if (cx == 2'd2) begin
            oi_r <= '0;
            if (cy == 2'd2) begin
              oj_r <= '0;
              ok_r <= ok_r + bs27_pkg::CZ_W'(1);
            end else begin
              oj_r <= oj_r + bs27_pkg::YI_W'(1);
            end
          end else begin
            oi_r <= oi_r + bs27_pkg::XI_W'(1);
          end
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
    if (out_load) begin
      out_res_r  <= mac_res;
      out_last_r <= is_last;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.result_x  = out_res_r.x;
  assign out_ch.result_y  = out_res_r.y;
  assign out_ch.result_z  = out_res_r.z;
  assign out_ch.clipped   = out_res_r.clip;
  assign out_ch.node_last = out_last_r;

  // Storage and arithmetic
  bs27_coef_store u_coef (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (coef_wr),
    .rd_row  (crow),
    .rd_data (coef_rd),
    .busy    (coef_busy)
  );

  bs27_win_store u_win (
    .clk   (clk),
    .we    (step_samp),
    .waddr (in_addr_r),
    .wdata ({in_ch.sample_z, in_ch.sample_y, in_ch.sample_x}),
    .raddr (nadj[bs27_pkg::SW_AW-1:0]),
    .rdata (win_rd)
  );

  assign mac_ctl.clr    = step_emit;
  assign mac_ctl.vld    = v1_r;
  assign mac_ctl.use_nb = u1_r;

  bs27_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .coef  (coef_rd),
    .samp  (win_rd),
    .res   (mac_res)
  );

  // Checks
  a_run_flow: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |=> (state_r == ST_RUN || state_r == ST_FLUSH))
    else $error("neighbor sweep left early");
  a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_pos_r < t_r)
    else $error("emitted node beyond mesh");
  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (in_addr_r < bs27_pkg::SW_AW'(bs27_pkg::SW_DEPTH)) &&
    (oa_r < bs27_pkg::SW_AW'(bs27_pkg::SW_DEPTH)))
    else $error("window pointer out of range");
  a_no_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> !coef_busy)
    else $error("sweep while table clearing");

endmodule
